// File: src/rc4_pkg.sv
// ----------------------------------------------------------------------------
// rc4_pkg
// Shared widths, control word layout and status bundle for the rc4 block.
// ----------------------------------------------------------------------------
package rc4_pkg;

	// data path widths
	localparam int BYTE_W        = 8;
	localparam int PERM_DEPTH    = 256;
	localparam int MAX_KEY_BYTES = 32;
	localparam int KCNT_W        = $clog2(MAX_KEY_BYTES + 1);
	localparam int KADDR_W       = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
	localparam int UPC_W         = 4;

	typedef logic [BYTE_W-1:0] byte_t;

	// permutation read address source
	typedef enum logic [1:0] {
		RD_I,   // index i
		RD_I1,  // index i plus one
		RD_J,   // updated index j
		RD_T    // S[i] + S[j]
	} rd_sel_t;

	// permutation write source
	typedef enum logic [1:0] {
		WR_NONE,
		WR_I,   // S[i] <= read data
		WR_J    // S[j] <= saved S[i]
	} wr_sel_t;

	// sequencing mode
	typedef enum logic [1:0] {
		BR_NEXT,  // step + 1
		BR_JUMP,  // cond ? target : step + 1
		BR_HOLD   // cond ? target : step
	} branch_t;

	// branch conditions
	typedef enum logic [2:0] {
		C_TRUE,
		C_ACCEPT,
		C_DATA,
		C_MORE_KEY,
		C_MORE_ROUNDS,
		C_OUT_FREE
	} cond_t;

	// one microcode word
	typedef struct packed {
		logic             in_rdy;
		logic             rd_en;
		rd_sel_t          rd_sel;
		wr_sel_t          wr_sel;
		logic             perm_clr;
		logic             i_inc;
		logic             i_clr;
		logic             j_ld;
		logic             j_clr;
		logic             use_key;
		logic             si_ld;
		logic             sj_ld;
		logic             t_ld;
		logic             out_ld;
		logic             key_wr;
		logic             kpos_adv;
		logic             kpos_clr;
		logic             kcnt_clr;
		branch_t          br;
		cond_t            cond;
		logic [UPC_W-1:0] target;
	} ctrl_t;

	// datapath status seen by the sequencer
	typedef struct packed {
		logic accept;
		logic act_data;
		logic more_key;
		logic more_rounds;
		logic out_free;
	} status_t;

endpackage

// File: src/rc4_perm_ram.sv
// ----------------------------------------------------------------------------
// rc4_perm_ram
// Permutation memory: one write and one registered read port, with a valid
// bit per entry so that an unwritten entry reads as its own address.
// ----------------------------------------------------------------------------
module rc4_perm_ram (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          clr,
	input  logic          re,
	input  rc4_pkg::byte_t raddr,
	output rc4_pkg::byte_t rdata,
	input  logic          we,
	input  rc4_pkg::byte_t waddr,
	input  rc4_pkg::byte_t wdata
);

	rc4_pkg::byte_t                      mem_q [rc4_pkg::PERM_DEPTH];
	logic [rc4_pkg::PERM_DEPTH-1:0]      valid_q;
	rc4_pkg::byte_t                      rdata_q;

	// valid bits: cleared at reset and on a new schedule
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (clr) begin
			valid_q <= '0;
		end else if (we) begin
			valid_q[waddr] <= 1'b1;
		end
	end

	// storage and registered read, identity where not yet written
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= valid_q[raddr] ? mem_q[raddr] : raddr;
		end
	end

	assign rdata = rdata_q;

endmodule

// File: src/rc4_useq.sv
// ----------------------------------------------------------------------------
// rc4_useq
// Microcode sequencer: step counter, control store and conditional branch.
// ----------------------------------------------------------------------------
module rc4_useq (
	input  logic             clk,
	input  logic             arst_n,
	input  rc4_pkg::status_t stat,
	output rc4_pkg::ctrl_t   cw
);

	typedef enum logic [rc4_pkg::UPC_W-1:0] {
		ST_IDLE,
		ST_DISP,
		ST_KEYW,
		ST_SINIT,
		ST_S0,
		ST_S1,
		ST_S2,
		ST_S3,
		ST_SDONE,
		ST_K0,
		ST_K1,
		ST_K2,
		ST_K3
	} step_t;

	step_t upc_q;
	step_t upc_d;
	step_t upc_inc;
	logic  hit;

	// control store
	always_comb begin
		cw = '0;
		unique case (upc_q)
			ST_IDLE: begin
				cw.in_rdy = 1'b1;
				cw.br     = rc4_pkg::BR_HOLD;
				cw.cond   = rc4_pkg::C_ACCEPT;
				cw.target = ST_DISP;
			end
			ST_DISP: begin
				cw.br     = rc4_pkg::BR_JUMP;
				cw.cond   = rc4_pkg::C_DATA;
				cw.target = ST_K0;
			end
			ST_KEYW: begin
				cw.key_wr = 1'b1;
				cw.br     = rc4_pkg::BR_JUMP;
				cw.cond   = rc4_pkg::C_MORE_KEY;
				cw.target = ST_IDLE;
			end
			ST_SINIT: begin
				cw.perm_clr = 1'b1;
				cw.i_clr    = 1'b1;
				cw.j_clr    = 1'b1;
				cw.kpos_clr = 1'b1;
			end
			ST_S0: begin
				cw.rd_en  = 1'b1;
				cw.rd_sel = rc4_pkg::RD_I;
			end
			ST_S1: begin
				cw.rd_en   = 1'b1;
				cw.rd_sel  = rc4_pkg::RD_J;
				cw.si_ld   = 1'b1;
				cw.j_ld    = 1'b1;
				cw.use_key = 1'b1;
			end
			ST_S2: begin
				cw.wr_sel = rc4_pkg::WR_I;
			end
			ST_S3: begin
				cw.wr_sel   = rc4_pkg::WR_J;
				cw.i_inc    = 1'b1;
				cw.kpos_adv = 1'b1;
				cw.br       = rc4_pkg::BR_JUMP;
				cw.cond     = rc4_pkg::C_MORE_ROUNDS;
				cw.target   = ST_S0;
			end
			ST_SDONE: begin
				cw.i_clr    = 1'b1;
				cw.j_clr    = 1'b1;
				cw.kcnt_clr = 1'b1;
				cw.br       = rc4_pkg::BR_JUMP;
				cw.cond     = rc4_pkg::C_TRUE;
				cw.target   = ST_IDLE;
			end
			ST_K0: begin
				cw.rd_en  = 1'b1;
				cw.rd_sel = rc4_pkg::RD_I1;
				cw.i_inc  = 1'b1;
			end
			ST_K1: begin
				cw.rd_en  = 1'b1;
				cw.rd_sel = rc4_pkg::RD_J;
				cw.si_ld  = 1'b1;
				cw.j_ld   = 1'b1;
			end
			ST_K2: begin
				cw.rd_en  = 1'b1;
				cw.rd_sel = rc4_pkg::RD_T;
				cw.wr_sel = rc4_pkg::WR_I;
				cw.sj_ld  = 1'b1;
				cw.t_ld   = 1'b1;
			end
			ST_K3: begin
				cw.wr_sel = rc4_pkg::WR_J;
				cw.out_ld = 1'b1;
				cw.br     = rc4_pkg::BR_HOLD;
				cw.cond   = rc4_pkg::C_OUT_FREE;
				cw.target = ST_IDLE;
			end
			default: begin
				cw.br     = rc4_pkg::BR_JUMP;
				cw.cond   = rc4_pkg::C_TRUE;
				cw.target = ST_IDLE;
			end
		endcase
	end

	// branch condition select
	always_comb begin
		unique case (cw.cond)
			rc4_pkg::C_TRUE:        hit = 1'b1;
			rc4_pkg::C_ACCEPT:      hit = stat.accept;
			rc4_pkg::C_DATA:        hit = stat.act_data;
			rc4_pkg::C_MORE_KEY:    hit = stat.more_key;
			rc4_pkg::C_MORE_ROUNDS: hit = stat.more_rounds;
			rc4_pkg::C_OUT_FREE:    hit = stat.out_free;
			default:                hit = 1'b1;
		endcase
	end

	// next step
	assign upc_inc = step_t'(upc_q + 1'b1);

	always_comb begin
		unique case (cw.br)
			rc4_pkg::BR_NEXT: upc_d = upc_inc;
			rc4_pkg::BR_JUMP: upc_d = hit ? step_t'(cw.target) : upc_inc;
			rc4_pkg::BR_HOLD: upc_d = hit ? step_t'(cw.target) : upc_q;
			default:          upc_d = ST_IDLE;
		endcase
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= ST_IDLE;
		end else begin
			upc_q <= upc_d;
		end
	end

endmodule

// File: src/rc4_stream_cipher.sv
// ----------------------------------------------------------------------------
// rc4_stream_cipher
// RC4 stream cipher: key bytes fill a key store, the last key byte runs the
// key schedule, data bytes come back XORed with the keystream.
// ----------------------------------------------------------------------------
//  channel  ports                                   beat
//  item     item_valid/item_ready, action,          one key byte or data byte
//           value, key_last
//  result   result_valid/result_ready, out_byte     one ciphered byte
//
//  data byte: four permutation memory steps, and the next beat is taken only
//  once the result is loaded; key byte: a key store write; last key byte
//  adds the schedule, a swap round for every permutation entry
//  a waiting result does not block the next beat; a second result waits in
//  the last data step until the output register is free
//  reset gives the identity permutation, zero indices and an empty key
module rc4_stream_cipher (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_ready,
	input  logic           action,
	input  rc4_pkg::byte_t value,
	input  logic           key_last,
	output logic           result_valid,
	input  logic           result_ready,
	output rc4_pkg::byte_t out_byte
);

	rc4_pkg::ctrl_t   cw;
	rc4_pkg::status_t stat;

	logic           accept;
	logic           out_free;
	logic           act_q;
	logic           klast_q;
	rc4_pkg::byte_t val_q;

	rc4_pkg::byte_t i_q;
	rc4_pkg::byte_t j_q;
	rc4_pkg::byte_t si_q;
	rc4_pkg::byte_t sj_q;
	rc4_pkg::byte_t t_q;
	rc4_pkg::byte_t j_sum;
	rc4_pkg::byte_t ks;

	rc4_pkg::byte_t raddr;
	rc4_pkg::byte_t rdata;
	logic           we;
	rc4_pkg::byte_t waddr;
	rc4_pkg::byte_t wdata;

	rc4_pkg::byte_t                  key_mem_q [rc4_pkg::MAX_KEY_BYTES];
	rc4_pkg::byte_t                  kdata_q;
	logic [rc4_pkg::KCNT_W-1:0]      kcnt_q;
	logic [rc4_pkg::KADDR_W-1:0]     kpos_q;
	logic [rc4_pkg::KCNT_W:0]        kpos_ext;
	logic                            kpos_wrap;
	logic                            key_room;

	rc4_pkg::byte_t out_byte_q;
	logic           result_valid_q;

	// sequencer
	rc4_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cw     (cw)
	);

	// permutation memory
	rc4_perm_ram u_perm (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (cw.perm_clr),
		.re     (cw.rd_en),
		.raddr  (raddr),
		.rdata  (rdata),
		.we     (we),
		.waddr  (waddr),
		.wdata  (wdata)
	);

	// handshake
	assign item_ready = cw.in_rdy;
	assign accept     = item_valid && item_ready;
	assign out_free   = !result_valid_q || result_ready;

	assign stat.accept      = accept;
	assign stat.act_data    = act_q;
	assign stat.more_key    = !klast_q;
	assign stat.more_rounds = (i_q != rc4_pkg::byte_t'(rc4_pkg::PERM_DEPTH - 1));
	assign stat.out_free    = out_free;

	// input beat capture
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q   <= action;
			val_q   <= value;
			klast_q <= key_last;
		end
	end

	// index j update, with the key byte during the schedule
	assign j_sum = j_q + rdata + (cw.use_key ? kdata_q : rc4_pkg::byte_t'(0));

	// permutation read address
	always_comb begin
		unique case (cw.rd_sel)
			rc4_pkg::RD_I:  raddr = i_q;
			rc4_pkg::RD_I1: raddr = i_q + 1'b1;
			rc4_pkg::RD_J:  raddr = j_sum;
			rc4_pkg::RD_T:  raddr = si_q + rdata;
			default:        raddr = i_q;
		endcase
	end

	// permutation write port
	always_comb begin
		we    = 1'b0;
		waddr = i_q;
		wdata = rdata;
		unique case (cw.wr_sel)
			rc4_pkg::WR_I: begin
				we    = 1'b1;
				waddr = i_q;
				wdata = rdata;
			end
			rc4_pkg::WR_J: begin
				we    = 1'b1;
				waddr = j_q;
				wdata = si_q;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	// indices
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0;
			j_q <= '0;
		end else begin
			if (cw.i_clr) begin
				i_q <= '0;
			end else if (cw.i_inc) begin
				i_q <= i_q + 1'b1;
			end
			if (cw.j_clr) begin
				j_q <= '0;
			end else if (cw.j_ld) begin
				j_q <= j_sum;
			end
		end
	end

	// swap operands and output address
	always_ff @(posedge clk) begin
		if (cw.si_ld) begin
			si_q <= rdata;
		end
		if (cw.sj_ld) begin
			sj_q <= rdata;
		end
		if (cw.t_ld) begin
			t_q <= si_q + rdata;
		end
	end

	// keystream byte, forwarding the swap not yet seen by the read
	always_comb begin
		priority if (t_q == j_q) begin
			ks = si_q;
		end else if (t_q == i_q) begin
			ks = sj_q;
		end else begin
			ks = rdata;
		end
	end

	// key store control
	assign key_room  = (kcnt_q < rc4_pkg::KCNT_W'(rc4_pkg::MAX_KEY_BYTES));
	assign kpos_ext  = (rc4_pkg::KCNT_W + 1)'(kpos_q) + 1'b1;
	assign kpos_wrap = (kpos_ext >= (rc4_pkg::KCNT_W + 1)'(kcnt_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kcnt_q <= '0;
			kpos_q <= '0;
		end else begin
			if (cw.kcnt_clr) begin
				kcnt_q <= '0;
			end else if (cw.key_wr && key_room) begin
				kcnt_q <= kcnt_q + 1'b1;
			end
			if (cw.kpos_clr) begin
				kpos_q <= '0;
			end else if (cw.kpos_adv) begin
				kpos_q <= kpos_wrap ? '0 : kpos_ext[rc4_pkg::KADDR_W-1:0];
			end
		end
	end

	// key store memory
	always_ff @(posedge clk) begin
		if (cw.key_wr && key_room) begin
			key_mem_q[kcnt_q[rc4_pkg::KADDR_W-1:0]] <= val_q;
		end
		kdata_q <= key_mem_q[kpos_q];
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cw.out_ld && out_free) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cw.out_ld && out_free) begin
			out_byte_q <= val_q ^ ks;
		end
	end

	assign result_valid = result_valid_q;
	assign out_byte     = out_byte_q;

endmodule
